// ===== src/llrp_pkg.sv =====
// Shared types and constants of the least-loaded row packer.
package llrp_pkg;

   localparam int MAX_ROWS_DEFAULT = 64;
   localparam int GLYPH_W   = 12;
   localparam int ROWS_W    = 7;
   localparam int PAD_W     = 9;
   localparam int CSR_W     = 9;
   localparam int WIDTH_W   = 16;
   localparam int ROW_OUT_W = 6;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   localparam logic CSR_ROWS_IN_USE = 1'b0;
   localparam logic CSR_PAD_PIXELS  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic start;
      logic scan;
      logic update;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic out_free;
   } ctrl_status_type;

endpackage

// ===== src/least_loaded_row_packer.sv =====
// Top level of the least-loaded row packer for glyph atlases.
//
// Each glyph transaction on the req_ channel carries one glyph width; the
// block places it on the row that is currently narrowest (lowest index on
// ties), grows that row by the glyph width plus the padding and returns one
// rsp_ transaction with the chosen row and the widest row so far.
// req_tlast marks the final glyph of a set; the next glyph starts a new set
// with every row at twice the padding, and rsp_tlast echoes the marker.
// Configuration is written through csr_ (index 0 is rows_in_use, index 1 is
// pad_pixels); the user must write it only while the block is idle, as the
// block itself does not enforce this.
// Timing: the argmin scan reads one row width per cycle from the row RAM over
// the active rows, and the row update then loads the result register; a new
// glyph can be accepted in the cycle after that update, not before. The single
// read port of the row RAM sets this scan rate.
// A finished result sits in an output register; the next glyph is accepted
// and scanned while rsp_tready is low, and only its final row update waits
// for that register to drain. Synchronous reset restores the register
// defaults and marks no set as open, so no clearing pass is needed.
module least_loaded_row_packer #(
   parameter int MAX_ROWS = llrp_pkg::MAX_ROWS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [llrp_pkg::REQ_DATA_W-1:0]    req_tdata,  // [11:0] glyph_width
   input  logic                               req_tlast,  // last_glyph
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [llrp_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // [5:0] row_chosen, [21:6] widest_row
   output logic                               rsp_tlast,  // set_done
   input  logic                               csr_wr_en,
   input  logic                               csr_addr,
   input  logic [llrp_pkg::CSR_W-1:0]         csr_wdata
);

   import llrp_pkg::*;

   localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   logic               ram_wr_en;
   logic [RW-1:0]      ram_wr_addr;
   logic [WIDTH_W-1:0] ram_wr_data;
   logic               ram_rd_en;
   logic [RW-1:0]      ram_rd_addr;
   logic [WIDTH_W-1:0] ram_rd_data;

   // The controller sequences acceptance, the row scan and the row update.
   llrp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath holds the configuration, the scan registers and the result.
   llrp_dpath #(
      .MAX_ROWS (MAX_ROWS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .csr_wr_en   (csr_wr_en),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   // Row widths live in RAM; rows not yet written in a set read as the start width.
   llrp_ram #(
      .WIDTH (WIDTH_W),
      .DEPTH (MAX_ROWS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

// ===== src/llrp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module llrp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/llrp_ctrl.sv =====
// Controller state machine of the row packer: accept, scan, update.
module llrp_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  llrp_pkg::ctrl_status_type status,
   output llrp_pkg::ctrl_cmd_type    cmd
);

   import llrp_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_done) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.start  = req_tvalid;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         ST_UPDATE: begin
            cmd.update = status.out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

// ===== src/llrp_dpath.sv =====
// Datapath of the row packer: registers, argmin scan, row update and result register.
module llrp_dpath #(
   parameter int MAX_ROWS = llrp_pkg::MAX_ROWS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  llrp_pkg::ctrl_cmd_type                 cmd,
   output llrp_pkg::ctrl_status_type              status,
   input  logic                                   csr_wr_en,
   input  logic                                   csr_addr,
   input  logic [llrp_pkg::CSR_W-1:0]             csr_wdata,
   input  logic [llrp_pkg::REQ_DATA_W-1:0]        req_tdata,
   input  logic                                   req_tlast,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [llrp_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic                                   rsp_tlast,
   output logic                                   ram_wr_en,
   output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] ram_wr_addr,
   output logic [llrp_pkg::WIDTH_W-1:0]           ram_wr_data,
   output logic                                   ram_rd_en,
   output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] ram_rd_addr,
   input  logic [llrp_pkg::WIDTH_W-1:0]           ram_rd_data
);

   import llrp_pkg::*;

   localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW = $clog2(MAX_ROWS + 1);

   logic [ROWS_W-1:0]  rows_ff;
   logic [PAD_W-1:0]   pad_ff;
   logic               in_set_ff;
   logic [WIDTH_W-1:0] base_ff;
   logic [WIDTH_W-1:0] max_ff;
   logic [MAX_ROWS-1:0] valid_ff;
   logic [GLYPH_W-1:0] glyph_ff;
   logic               last_ff;
   logic [CW-1:0]      iss_ff;
   logic               data_vld_ff;
   logic [RW-1:0]      data_idx_ff;
   logic [RW-1:0]      best_ff;
   logic [WIDTH_W-1:0] best_val_ff;
   logic               rsp_valid_ff;
   logic [ROW_OUT_W-1:0] rsp_row_ff;
   logic [WIDTH_W-1:0] rsp_widest_ff;
   logic               rsp_last_ff;

   logic [CW-1:0]      n_rows;
   logic               issue;
   logic [WIDTH_W-1:0] cand_val;
   logic [WIDTH_W:0]   sum;
   logic [WIDTH_W-1:0] grown;
   logic [WIDTH_W-1:0] new_max;

   // Active row count: zero counts as one, and the count is capped at the row storage.
   always_comb begin
      if (rows_ff == '0) begin
         n_rows = CW'(1);
      end else if (int'(rows_ff) > MAX_ROWS) begin
         n_rows = CW'(MAX_ROWS);
      end else begin
         n_rows = CW'(rows_ff);
      end
   end

   assign issue    = cmd.scan && (iss_ff < n_rows);
   assign cand_val = valid_ff[data_idx_ff] ? ram_rd_data : base_ff;
   assign sum      = {1'b0, best_val_ff} + (WIDTH_W + 1)'(glyph_ff) + (WIDTH_W + 1)'(pad_ff);
   assign grown    = sum[WIDTH_W] ? '1 : sum[WIDTH_W-1:0];
   assign new_max  = (grown > max_ff) ? grown : max_ff;

   assign status.scan_done = (iss_ff == n_rows) && data_vld_ff;
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   assign ram_rd_en   = issue;
   assign ram_rd_addr = iss_ff[RW-1:0];
   assign ram_wr_en   = cmd.update;
   assign ram_wr_addr = best_ff;
   assign ram_wr_data = grown;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff      <= ROWS_W'(1);
         pad_ff       <= '0;
         in_set_ff    <= 1'b0;
         valid_ff     <= '0;
         data_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_addr)
               CSR_ROWS_IN_USE: rows_ff <= csr_wdata[ROWS_W-1:0];
               CSR_PAD_PIXELS:  pad_ff  <= csr_wdata[PAD_W-1:0];
               default:         rows_ff <= rows_ff;
            endcase
         end
         if (cmd.start && !in_set_ff) begin
            in_set_ff <= 1'b1;
            valid_ff  <= '0;
         end else if (cmd.update) begin
            valid_ff[best_ff] <= 1'b1;
            if (last_ff) in_set_ff <= 1'b0;
         end
         if (cmd.start) begin
            data_vld_ff <= 1'b0;
         end else begin
            data_vld_ff <= issue;
         end
         if (cmd.update) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         glyph_ff <= req_tdata[GLYPH_W-1:0];
         last_ff  <= req_tlast;
         iss_ff   <= '0;
         if (!in_set_ff) begin
            base_ff <= WIDTH_W'({pad_ff, 1'b0});
            max_ff  <= WIDTH_W'({pad_ff, 1'b0});
         end
      end
      if (issue) begin
         iss_ff      <= iss_ff + CW'(1);
         data_idx_ff <= iss_ff[RW-1:0];
      end
      // Strict compare keeps the lowest index on equal widths.
      if (cmd.scan && data_vld_ff) begin
         if (data_idx_ff == '0 || cand_val < best_val_ff) begin
            best_ff     <= data_idx_ff;
            best_val_ff <= cand_val;
         end
      end
      if (cmd.update) begin
         max_ff        <= new_max;
         rsp_row_ff    <= ROW_OUT_W'(best_ff);
         rsp_widest_ff <= new_max;
         rsp_last_ff   <= last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - ROW_OUT_W - WIDTH_W){1'b0}}, rsp_widest_ff, rsp_row_ff};
   assign rsp_tlast  = rsp_last_ff;

   a_update_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> status.out_free)
      else $error("row update issued while the result register is still occupied");

   a_best_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> (int'(best_ff) < int'(n_rows)))
      else $error("chosen row lies outside the active rows");

   a_result_follows_update: assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> rsp_valid_ff && (rsp_widest_ff == $past(new_max)))
      else $error("row update did not load the result register");

   a_max_not_below_base: assert property (@(posedge clock) disable iff (reset)
      (in_set_ff && !cmd.start) |-> (max_ff >= base_ff))
      else $error("widest row dropped below the row start width");

endmodule
